FILE: design/bus_decode_and_keyboard_io_defines.svh
// Assertion macros used by the checker file.
`ifndef BUS_DECODE_AND_KEYBOARD_IO_DEFINES_SVH
`define BUS_DECODE_AND_KEYBOARD_IO_DEFINES_SVH
// Checks that a condition implies a consequence on the next clock edge.
`define BDK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Checks that a condition implies a consequence on the same clock edge.
`define BDK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

FILE: design/bdk_pkg.sv
// Package with the item types, operation codes and the typed character table.
`default_nettype none
package bdk_pkg;
    localparam int RamDepth = 65536;
    localparam int RingDepth = 256;
    localparam int MatrixRows = 10;
    localparam int RamAw = $clog2(RamDepth);
    localparam int RingAw = $clog2(RingDepth);
    localparam int RowAw = $clog2(MatrixRows);

    typedef enum logic [2:0] {
        OP_READ = 3'd0, OP_WRITE = 3'd1, OP_ROM_LOAD = 3'd2,
        OP_KEY_PRESS = 3'd3, OP_KEY_RELEASE = 3'd4, OP_QUEUE_CHAR = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [7:0]  data;
        logic [3:0]  key_row;
        logic [3:0]  key_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       queue_full;
    } t_out_item;

    typedef struct packed {
        logic       hit;
        logic [2:0] row;
        logic [2:0] col;
    } t_key_pos;

    // Maps a typed character (already upper case) to its matrix position.
    function automatic t_key_pos key_lookup(input logic [7:0] ch);
        t_key_pos p;
        p = '{hit: 1'b1, row: 3'd0, col: 3'd0};
        unique case (ch)
            8'h31: p = '{1'b1, 3'd0, 3'd0}; 8'h32: p = '{1'b1, 3'd0, 3'd1};
            8'h33: p = '{1'b1, 3'd0, 3'd2}; 8'h34: p = '{1'b1, 3'd0, 3'd3};
            8'h35: p = '{1'b1, 3'd0, 3'd4}; 8'h36: p = '{1'b1, 3'd0, 3'd5};
            8'h37: p = '{1'b1, 3'd0, 3'd6}; 8'h38: p = '{1'b1, 3'd0, 3'd7};
            8'h51: p = '{1'b1, 3'd1, 3'd0}; 8'h57: p = '{1'b1, 3'd1, 3'd1};
            8'h45: p = '{1'b1, 3'd1, 3'd2}; 8'h52: p = '{1'b1, 3'd1, 3'd3};
            8'h54: p = '{1'b1, 3'd1, 3'd4}; 8'h59: p = '{1'b1, 3'd1, 3'd5};
            8'h55: p = '{1'b1, 3'd1, 3'd6}; 8'h49: p = '{1'b1, 3'd1, 3'd7};
            8'h41: p = '{1'b1, 3'd2, 3'd0}; 8'h53: p = '{1'b1, 3'd2, 3'd1};
            8'h44: p = '{1'b1, 3'd2, 3'd2}; 8'h46: p = '{1'b1, 3'd2, 3'd3};
            8'h47: p = '{1'b1, 3'd2, 3'd4}; 8'h48: p = '{1'b1, 3'd2, 3'd5};
            8'h4a: p = '{1'b1, 3'd2, 3'd6}; 8'h4b: p = '{1'b1, 3'd2, 3'd7};
            8'h5a: p = '{1'b1, 3'd3, 3'd0}; 8'h58: p = '{1'b1, 3'd3, 3'd1};
            8'h43: p = '{1'b1, 3'd3, 3'd2}; 8'h56: p = '{1'b1, 3'd3, 3'd3};
            8'h42: p = '{1'b1, 3'd3, 3'd4}; 8'h4e: p = '{1'b1, 3'd3, 3'd5};
            8'h4d: p = '{1'b1, 3'd3, 3'd6}; 8'h2c: p = '{1'b1, 3'd3, 3'd7};
            8'h39: p = '{1'b1, 3'd4, 3'd0}; 8'h30: p = '{1'b1, 3'd4, 3'd1};
            8'h2d: p = '{1'b1, 3'd4, 3'd2}; 8'h3d: p = '{1'b1, 3'd4, 3'd3};
            8'h0d: p = '{1'b1, 3'd4, 3'd4}; 8'h0a: p = '{1'b1, 3'd4, 3'd4};
            8'h08: p = '{1'b1, 3'd4, 3'd5}; 8'h20: p = '{1'b1, 3'd4, 3'd6};
            8'h4f: p = '{1'b1, 3'd5, 3'd0}; 8'h50: p = '{1'b1, 3'd5, 3'd1};
            8'h5b: p = '{1'b1, 3'd5, 3'd2}; 8'h5d: p = '{1'b1, 3'd5, 3'd3};
            8'h4c: p = '{1'b1, 3'd6, 3'd0}; 8'h3b: p = '{1'b1, 3'd6, 3'd1};
            8'h3a: p = '{1'b1, 3'd6, 3'd2};
            8'h2e: p = '{1'b1, 3'd7, 3'd0}; 8'h2f: p = '{1'b1, 3'd7, 3'd1};
            default: p = '{1'b0, 3'd0, 3'd0};
        endcase
        return p;
    endfunction
endpackage
`default_nettype wire

FILE: design/bus_decode_and_keyboard_io.sv
// Each item is registered on acceptance in ST_IDLE, issues its memory access
// in ST_MEM and gives its result in ST_OUT; a new item is accepted only after
// the result has been taken, as items do not overlap.
// Reset: synchronous, active low. After reset a clearing pass sweeps all 65536
// bytes of main RAM, one byte a cycle, during which no item is accepted.
`default_nettype none
module bus_decode_and_keyboard_io (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire bdk_pkg::t_in_item    i_item,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output bdk_pkg::t_out_item        o_item
);
    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MEM, ST_OUT} t_state;

    t_state r_state;
    logic [bdk_pkg::RamAw:0] r_clr;
    bdk_pkg::t_in_item r_it;
    logic [7:0] r_rows [bdk_pkg::MatrixRows];
    logic [bdk_pkg::RingAw-1:0] r_head, r_tail;
    logic r_pv;
    logic [2:0] r_prow, r_pcol;
    logic [7:0] r_pa, r_cra, r_crb;
    logic [7:0] r_via [16];
    logic [4:0] r_csel;
    logic [7:0] r_crtc [32];
    logic [7:0] r_io;
    logic [1:0] r_src;
    logic       r_full;

    localparam logic [1:0] SRC_RAM = 2'd0, SRC_ROM = 2'd1, SRC_IO = 2'd2, SRC_ZERO = 2'd3;

    // Memory ports.
    logic ram_we, basic_we, edit_we, kern_we, ring_we;
    logic [bdk_pkg::RamAw-1:0] ram_a;
    logic [7:0] ram_wd, ram_q, basic_q, edit_q, kern_q, ring_q;
    logic [bdk_pkg::RingAw-1:0] ring_a;

    logic [15:0] a;
    logic is_basic, is_edit, is_io, is_kern, in_ram;
    assign a = r_it.address;
    assign is_basic = a >= 16'hc000 && a <= 16'hdfff;
    assign is_edit = a >= 16'he000 && a <= 16'he7ff;
    assign is_io = a >= 16'he800 && a <= 16'he8ff;
    assign is_kern = a >= 16'hf000;
    assign in_ram = 32'(a) < 32'(bdk_pkg::RamDepth);

    // Accepted item is registered in ST_IDLE; memory accesses issue in ST_MEM.
    logic issue;
    assign issue = r_state == ST_MEM;

    always_comb begin
        ram_we = 1'b0;
        ram_a = a[bdk_pkg::RamAw-1:0];
        ram_wd = r_it.data;
        if (r_state == ST_CLEAR) begin
            ram_we = 1'b1;
            ram_a = r_clr[bdk_pkg::RamAw-1:0];
            ram_wd = 8'h00;
        end else if (issue && r_it.operation == bdk_pkg::OP_WRITE && !is_basic && !is_edit
                     && !is_io && !is_kern && in_ram) begin
            ram_we = 1'b1;
        end
    end

    assign basic_we = issue && r_it.operation == bdk_pkg::OP_ROM_LOAD && is_basic;
    assign edit_we = issue && r_it.operation == bdk_pkg::OP_ROM_LOAD && is_edit;
    assign kern_we = issue && r_it.operation == bdk_pkg::OP_ROM_LOAD && is_kern;

    // Keyboard port: only one ring read is needed, and the head entry is read
    // ahead while idle, so the lookup is done in the issue cycle.
    logic q_op, q_full;
    logic [bdk_pkg::RingAw-1:0] tail_nx;
    assign q_op = issue && r_it.operation == bdk_pkg::OP_QUEUE_CHAR && r_it.data != 8'h00;
    assign tail_nx = r_tail + 1'b1;
    assign q_full = tail_nx == r_head;
    assign ring_we = q_op && !q_full;
    assign ring_a = ring_we ? r_tail : r_head;

    bdk_ram #(.Aw(bdk_pkg::RamAw)) u_ram (.i_clk, .i_we(ram_we), .i_addr(ram_a),
        .i_wdata(ram_wd), .o_rdata(ram_q));
    bdk_ram #(.Aw(13)) u_basic (.i_clk, .i_we(basic_we), .i_addr(a[12:0]),
        .i_wdata(r_it.data), .o_rdata(basic_q));
    bdk_ram #(.Aw(11)) u_edit (.i_clk, .i_we(edit_we), .i_addr(a[10:0]),
        .i_wdata(r_it.data), .o_rdata(edit_q));
    bdk_ram #(.Aw(12)) u_kern (.i_clk, .i_we(kern_we), .i_addr(a[11:0]),
        .i_wdata(r_it.data), .o_rdata(kern_q));
    bdk_ram #(.Aw(bdk_pkg::RingAw)) u_ring (.i_clk, .i_we(ring_we), .i_addr(ring_a),
        .i_wdata(r_it.data), .o_rdata(ring_q));

    // Ring head is read continuously while idle, so ring_q holds the head entry
    // at issue time; it is valid because the last write to the ring came in an
    // earlier item's ST_MEM, before the idle state.
    function automatic logic sel(input logic [7:0] pa, input logic [3:0] row);
        return pa == 8'h00 || row >= 4'd8 || !pa[row[2:0]];
    endfunction

    logic [7:0] kb_and;
    logic [7:0] ch_up;
    bdk_pkg::t_key_pos kp;
    logic kb_any_pend;
    logic [2:0] kb_row, kb_col;
    logic kb_pop, kb_show;
    logic [7:0] kb_val;
    always_comb begin
        kb_and = 8'hff;
        for (int r = 0; r < bdk_pkg::MatrixRows; r++) begin
            if (sel(r_pa, 4'(r))) begin
                kb_and = kb_and & r_rows[r];
            end
        end
        ch_up = (ring_q >= 8'h61 && ring_q <= 8'h7a) ? ring_q - 8'd32 : ring_q;
        kp = bdk_pkg::key_lookup(ch_up);
        kb_pop = 1'b0;
        kb_any_pend = r_pv;
        kb_row = r_prow;
        kb_col = r_pcol;
        if (kb_and == 8'hff && !r_pv && r_head != r_tail) begin
            kb_pop = 1'b1;
            kb_any_pend = kp.hit;
            kb_row = kp.hit ? kp.row : 3'd0;
            kb_col = kp.hit ? kp.col : 3'd0;
        end
        kb_show = kb_and == 8'hff && kb_any_pend && sel(r_pa, {1'b0, kb_row});
        kb_val = kb_and;
        if (kb_show) begin
            kb_val[kb_col] = 1'b0;
        end
    end

    logic is_rd;
    assign is_rd = r_it.operation == bdk_pkg::OP_READ;

    // Source of the read data and the I/O byte, worked out in the issue cycle.
    logic [1:0] n_src;
    logic [7:0] n_io;
    always_comb begin
        n_src = SRC_ZERO;
        n_io = 8'hff;
        if (is_rd) begin
            if (is_basic || is_edit || is_kern) n_src = SRC_ROM;
            else if (is_io) n_src = SRC_IO;
            else if (in_ram) n_src = SRC_RAM;
            else n_src = SRC_IO;
        end
        if (is_rd && is_io) begin
            if (a == 16'he810) n_io = r_pa;
            else if (a == 16'he811) n_io = r_cra;
            else if (a == 16'he813) n_io = r_crb;
            else if (a == 16'he880) n_io = {3'b000, r_csel};
            else if (a == 16'he881) n_io = r_crtc[r_csel];
            else if (a[7:4] == 4'h4) n_io = r_via[a[3:0]];
            else if (a == 16'he812) n_io = kb_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_pv <= 1'b0;
            r_prow <= '0;
            r_pcol <= '0;
            r_pa <= 8'hff;
            r_cra <= '0;
            r_crb <= '0;
            r_csel <= '0;
            r_full <= 1'b0;
            r_src <= SRC_ZERO;
            r_io <= '0;
            for (int i = 0; i < bdk_pkg::MatrixRows; i++) r_rows[i] <= 8'hff;
            for (int i = 0; i < 16; i++) r_via[i] <= '0;
            for (int i = 0; i < 32; i++) r_crtc[i] <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (bdk_pkg::RamAw+1)'(bdk_pkg::RamDepth - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_it <= i_item;
                        r_state <= ST_MEM;
                    end
                end
                ST_MEM: begin
                    r_full <= q_op && q_full;
                    if (ring_we) r_tail <= tail_nx;
                    r_src <= n_src;
                    r_io <= n_io;
                    // The flag is cleared after the VIA byte has been picked.
                    if (is_rd && a == 16'he844) r_via[13][6] <= 1'b0;
                    if (is_rd && a == 16'he812) begin
                        if (kb_pop) r_head <= r_head + 1'b1;
                        if (kb_show) begin
                            r_pv <= 1'b0;
                            r_prow <= '0;
                            r_pcol <= '0;
                        end else begin
                            r_pv <= kb_any_pend;
                            r_prow <= kb_row;
                            r_pcol <= kb_col;
                        end
                    end
                    if (r_it.operation == bdk_pkg::OP_WRITE && is_io) begin
                        if (a == 16'he810) r_pa <= r_it.data;
                        else if (a == 16'he811) r_cra <= r_it.data;
                        else if (a == 16'he813) r_crb <= r_it.data;
                        else if (a[7:4] == 4'h4) r_via[a[3:0]] <= r_it.data;
                        else if (a == 16'he880) r_csel <= r_it.data[4:0];
                        else if (a == 16'he881) r_crtc[r_csel] <= r_it.data;
                    end
                    if ((r_it.operation == bdk_pkg::OP_KEY_PRESS
                         || r_it.operation == bdk_pkg::OP_KEY_RELEASE)
                        && r_it.key_row < 4'(bdk_pkg::MatrixRows) && !r_it.key_col[3]) begin
                        r_rows[r_it.key_row[bdk_pkg::RowAw-1:0]][r_it.key_col[2:0]]
                            <= r_it.operation == bdk_pkg::OP_KEY_RELEASE;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ROM read data must be picked from the store that the address selected.
    logic [7:0] rom_q;
    assign rom_q = is_basic ? basic_q : (is_edit ? edit_q : kern_q);

    assign o_ready = r_state == ST_IDLE;
    assign o_valid = r_state == ST_OUT;
    always_comb begin
        unique case (r_src)
            SRC_RAM:  o_item.read_data = ram_q;
            SRC_ROM:  o_item.read_data = rom_q;
            SRC_IO:   o_item.read_data = r_io;
            default:  o_item.read_data = 8'h00;
        endcase
        o_item.queue_full = r_full;
    end
endmodule
`default_nettype wire

FILE: design/bdk_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module bdk_ram #(
    parameter int Aw = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [Aw-1:0] i_addr,
    input  wire logic [7:0]    i_wdata,
    output logic      [7:0]    o_rdata
);
    logic [7:0] r_mem [2**Aw];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: design/bdk_checker.sv
// Port-level checker for the bus decoder and keyboard block, with its bind.
`default_nettype none
`include "bus_decode_and_keyboard_io_defines.svh"
module bdk_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire bdk_pkg::t_out_item o_item
);
    `BDK_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `BDK_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `BDK_ASSERT_NOW(a_full_only_queue, i_clk, i_rst_n, o_valid && o_item.queue_full,
        o_item.read_data == 8'h00)
    `BDK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_item))
endmodule

bind bus_decode_and_keyboard_io bdk_checker u_bdk_checker (.*);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the bus decoder and keyboard interface.
`timescale 1ns / 100ps
module testbench;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    bdk_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_ready;
    bdk_pkg::t_out_item o_item;

    bus_decode_and_keyboard_io dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_item (o_item)
    );

    // Shadow copy of the block's state.
    logic [7:0] ram_shadow [0:65535];
    logic [7:0] basic_shadow [0:8191];
    logic [7:0] editor_shadow [0:2047];
    logic [7:0] kernal_shadow [0:4095];
    logic [7:0] rows_shadow [0:bdk_pkg::MatrixRows-1];
    logic [7:0] ring_shadow [0:bdk_pkg::RingDepth-1];
    int unsigned head_sh, tail_sh;
    logic       pend_v;
    logic [2:0] pend_row, pend_col;
    logic [7:0] port_a_sh, ctrl_a_sh, ctrl_b_sh;
    logic [7:0] via_sh [0:15];
    logic [4:0] crtc_sel_sh;
    logic [7:0] crtc_sh [0:31];

    // ROM bytes loaded so far, so that reads only reach loaded bytes.
    bit basic_ok [0:8191];
    bit editor_ok [0:2047];
    bit kernal_ok [0:4095];
    logic [15:0] loaded_roms [$];

    bdk_pkg::t_in_item  pending_items [$];
    bdk_pkg::t_out_item expected_results [$];
    int        mismatches;
    int        hold_off;
    int        burst_left, gap_left;
    int unsigned cycle_count;
    int        n_results;
    bit        stim_done;
    int        n_reads, n_typed;

    function automatic bit is_selected(int unsigned r);
        if (port_a_sh == 8'h00) return 1'b1;
        if (r >= 8) return 1'b1;
        return port_a_sh[r] == 1'b0;
    endfunction

    function automatic bit pull_typed();
        logic [7:0] ch;
        bdk_pkg::t_key_pos p;
        if (pend_v) return 1'b1;
        if (head_sh == tail_sh) return 1'b0;
        ch = ring_shadow[head_sh];
        head_sh = (head_sh + 1) % bdk_pkg::RingDepth;
        if (ch >= 8'h61 && ch <= 8'h7a) ch = ch - 8'd32;
        p = bdk_pkg::key_lookup(ch);
        if (p.hit) begin
            pend_v = 1'b1;
            pend_row = p.row;
            pend_col = p.col;
        end
        return p.hit;
    endfunction

    function automatic logic [7:0] scan_keyboard();
        logic [7:0] v;
        v = 8'hff;
        for (int r = 0; r < bdk_pkg::MatrixRows; r++)
            if (is_selected(r)) v &= rows_shadow[r];
        if (v == 8'hff && pull_typed() && is_selected(pend_row)) begin
            v[pend_col] = 1'b0;
            pend_v = 1'b0;
            pend_row = '0;
            pend_col = '0;
        end
        return v;
    endfunction

    function automatic logic [7:0] decode_read(logic [15:0] a);
        if (a >= 16'hc000 && a <= 16'hdfff) return basic_shadow[a - 16'hc000];
        if (a >= 16'he000 && a <= 16'he7ff) return editor_shadow[a - 16'he000];
        if (a >= 16'he800 && a <= 16'he8ff) begin
            if (a == 16'he810) return port_a_sh;
            if (a == 16'he811) return ctrl_a_sh;
            if (a == 16'he812) return scan_keyboard();
            if (a == 16'he813) return ctrl_b_sh;
            if (a >= 16'he840 && a <= 16'he84f) begin
                if (a == 16'he844) via_sh[13][6] = 1'b0;
                return via_sh[a[3:0]];
            end
            if (a == 16'he880) return {3'b000, crtc_sel_sh};
            if (a == 16'he881) return crtc_sh[crtc_sel_sh];
            return 8'hff;
        end
        if (a >= 16'hf000) return kernal_shadow[a - 16'hf000];
        return ram_shadow[a];
    endfunction

    function automatic void decode_write(logic [15:0] a, logic [7:0] v);
        if (a >= 16'hc000 && a <= 16'he7ff) return;
        if (a >= 16'hf000) return;
        if (a >= 16'he800 && a <= 16'he8ff) begin
            if (a == 16'he810) port_a_sh = v;
            else if (a == 16'he811) ctrl_a_sh = v;
            else if (a == 16'he813) ctrl_b_sh = v;
            else if (a >= 16'he840 && a <= 16'he84f) via_sh[a[3:0]] = v;
            else if (a == 16'he880) crtc_sel_sh = v[4:0];
            else if (a == 16'he881) crtc_sh[crtc_sel_sh] = v;
            return;
        end
        ram_shadow[a] = v;
    endfunction

    function automatic bdk_pkg::t_out_item predict_access(bdk_pkg::t_in_item it);
        bdk_pkg::t_out_item r;
        int unsigned nxt;
        r = '0;
        case (bdk_pkg::t_op'(it.operation))
            bdk_pkg::OP_READ: r.read_data = decode_read(it.address);
            bdk_pkg::OP_WRITE: decode_write(it.address, it.data);
            bdk_pkg::OP_ROM_LOAD: begin
                if (it.address >= 16'hc000 && it.address <= 16'hdfff)
                    basic_shadow[it.address - 16'hc000] = it.data;
                else if (it.address >= 16'he000 && it.address <= 16'he7ff)
                    editor_shadow[it.address - 16'he000] = it.data;
                else if (it.address >= 16'hf000)
                    kernal_shadow[it.address - 16'hf000] = it.data;
            end
            bdk_pkg::OP_KEY_PRESS, bdk_pkg::OP_KEY_RELEASE: begin
                if (it.key_row < bdk_pkg::MatrixRows && it.key_col < 8) begin
                    if (it.operation == bdk_pkg::OP_KEY_PRESS)
                        rows_shadow[it.key_row][it.key_col] = 1'b0;
                    else
                        rows_shadow[it.key_row][it.key_col] = 1'b1;
                end
            end
            bdk_pkg::OP_QUEUE_CHAR: begin
                if (it.data != 8'h00) begin
                    nxt = (tail_sh + 1) % bdk_pkg::RingDepth;
                    if (nxt == head_sh) r.queue_full = 1'b1;
                    else begin
                        ring_shadow[tail_sh] = it.data;
                        tail_sh = nxt;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Tells whether a ROM byte was loaded at stimulus time, so that only legal reads are sent.
    function automatic bit rom_readable(logic [15:0] a);
        if (a >= 16'hc000 && a <= 16'hdfff) return basic_ok[a - 16'hc000];
        if (a >= 16'he000 && a <= 16'he7ff) return editor_ok[a - 16'he000];
        if (a >= 16'hf000) return kernal_ok[a - 16'hf000];
        return 1'b1;
    endfunction

    function automatic void push_item(logic [2:0] op, logic [15:0] a, logic [7:0] d,
                                      logic [3:0] r, logic [3:0] c);
        bdk_pkg::t_in_item it;
        it = '{operation: op, address: a, data: d, key_row: r, key_col: c};
        if (op == bdk_pkg::OP_ROM_LOAD) begin
            if (a >= 16'hc000 && a <= 16'hdfff) basic_ok[a - 16'hc000] = 1'b1;
            else if (a >= 16'he000 && a <= 16'he7ff) editor_ok[a - 16'he000] = 1'b1;
            else if (a >= 16'hf000) kernal_ok[a - 16'hf000] = 1'b1;
            if ((a >= 16'hc000 && a <= 16'he7ff) || a >= 16'hf000) loaded_roms.push_back(a);
        end
        if (op == bdk_pkg::OP_READ && !rom_readable(a)) return;
        pending_items.push_back(it);
    endfunction

    function automatic logic [15:0] pick_address();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1: return 16'(($urandom_range(0, 1) ? 16'h0000 : 16'h7f00)
                             + $urandom_range(0, 15));
            2: return 16'he810 + 16'($urandom_range(0, 3));
            3: return 16'he840 + 16'($urandom_range(0, 15));
            4: return 16'he880 + 16'($urandom_range(0, 1));
            5: return 16'he800 + 16'($urandom_range(0, 255));
            6: begin
                if (loaded_roms.size() > 0)
                    return loaded_roms[$urandom_range(0, loaded_roms.size() - 1)];
                return 16'($urandom_range(0, 65535));
            end
            7: return 16'he812;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < 65536; i++) ram_shadow[i] = 8'h00;
        for (int i = 0; i < 8192; i++) begin basic_shadow[i] = 8'h00; basic_ok[i] = 0; end
        for (int i = 0; i < 2048; i++) begin editor_shadow[i] = 8'h00; editor_ok[i] = 0; end
        for (int i = 0; i < 4096; i++) begin kernal_shadow[i] = 8'h00; kernal_ok[i] = 0; end
        for (int i = 0; i < bdk_pkg::MatrixRows; i++) rows_shadow[i] = 8'hff;
        for (int i = 0; i < bdk_pkg::RingDepth; i++) ring_shadow[i] = 8'h00;
        for (int i = 0; i < 16; i++) via_sh[i] = 8'h00;
        for (int i = 0; i < 32; i++) crtc_sh[i] = 8'h00;
        head_sh = 0; tail_sh = 0;
        pend_v = 0; pend_row = 0; pend_col = 0;
        port_a_sh = 8'hff; ctrl_a_sh = 0; ctrl_b_sh = 0; crtc_sel_sh = 0;
        mismatches = 0; hold_off = 0; stim_done = 0;
        n_reads = 0; n_typed = 0;

        // Directed part: extremes, every operation and the named special cases.
        push_item(bdk_pkg::OP_READ, 16'h0000, 8'h00, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_WRITE, 16'h0000, 8'hff, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_WRITE, 16'hbfff, 8'h5a, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_READ, 16'hbfff, 8'h00, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_ROM_LOAD, 16'hc000, 8'ha5, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_ROM_LOAD, 16'he7ff, 8'h3c, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_ROM_LOAD, 16'hffff, 8'hc3, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_ROM_LOAD, 16'he820, 8'h11, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_WRITE, 16'hffff, 8'h00, 4'd0, 4'd0);   // ROM write ignored
        push_item(bdk_pkg::OP_READ, 16'hffff, 8'h00, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_READ, 16'he7ff, 8'h00, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_WRITE, 16'he84d, 8'hff, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_READ, 16'he844, 8'h00, 4'd0, 4'd0);    // clears VIA flag
        push_item(bdk_pkg::OP_READ, 16'he84d, 8'h00, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_READ, 16'he8ff, 8'h00, 4'd0, 4'd0);    // unused I/O
        push_item(bdk_pkg::OP_WRITE, 16'he880, 8'hff, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_WRITE, 16'he881, 8'h77, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_READ, 16'he881, 8'h00, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_KEY_PRESS, 16'h0, 8'h0, 4'd15, 4'd15); // bad position
        push_item(bdk_pkg::OP_KEY_PRESS, 16'h0, 8'h0, 4'd9, 4'd7);
        push_item(bdk_pkg::OP_READ, 16'he812, 8'h00, 4'd0, 4'd0);
        push_item(bdk_pkg::OP_KEY_RELEASE, 16'h0, 8'h0, 4'd9, 4'd7);
        push_item(bdk_pkg::OP_QUEUE_CHAR, 16'h0, 8'h00, 4'd0, 4'd0); // NUL ignored
        push_item(bdk_pkg::OP_QUEUE_CHAR, 16'h0, 8'h61, 4'd0, 4'd0); // lower case
        push_item(bdk_pkg::OP_QUEUE_CHAR, 16'h0, 8'h7e, 4'd0, 4'd0); // does not map
        push_item(bdk_pkg::OP_READ, 16'he812, 8'h00, 4'd0, 4'd0);
        push_item(3'd7, 16'hffff, 8'hff, 4'd15, 4'd15);

        while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        // Fill the ring to the brim so that queue_full shows, then drain a little.
        hold_off = 20;
        for (int i = 0; i < 260; i++)
            push_item(bdk_pkg::OP_QUEUE_CHAR, 16'h0, 8'h41 + 8'(i % 26), 4'd0, 4'd0);
        for (int i = 0; i < 10; i++)
            push_item(bdk_pkg::OP_READ, 16'he812, 8'h00, 4'd0, 4'd0);

        // Random part.
        for (int i = 0; i < 550; i++) begin
            int k;
            k = $urandom_range(0, 99);
            if (k < 30)
                push_item(bdk_pkg::OP_READ, pick_address(), 8'h00, 4'($urandom),
                          4'($urandom));
            else if (k < 50)
                push_item(bdk_pkg::OP_WRITE, pick_address(), 8'($urandom), 4'($urandom),
                          4'($urandom));
            else if (k < 58)
                push_item(bdk_pkg::OP_ROM_LOAD, 16'($urandom), 8'($urandom), 4'($urandom),
                          4'($urandom));
            else if (k < 68)
                push_item(bdk_pkg::OP_KEY_PRESS, 16'($urandom), 8'($urandom),
                          4'($urandom_range(0, 11)), 4'($urandom_range(0, 9)));
            else if (k < 78)
                push_item(bdk_pkg::OP_KEY_RELEASE, 16'($urandom), 8'($urandom),
                          4'($urandom_range(0, 11)), 4'($urandom_range(0, 9)));
            else if (k < 90)
                push_item(bdk_pkg::OP_QUEUE_CHAR, 16'($urandom),
                          8'($urandom_range(0, 3) == 0 ?
                          $urandom : 8'h41 + $urandom_range(0, 25)), 4'($urandom),
                          4'($urandom));
            else if (k < 97)
                push_item(bdk_pkg::OP_READ, 16'he812, 8'h00, 4'd0, 4'd0);
            else
                push_item(3'($urandom_range(6, 7)), 16'($urandom), 8'($urandom),
                          4'($urandom), 4'($urandom));
            if (i == 250) begin
                while (pending_items.size() > 0 || expected_results.size() > 0)
                    @(posedge i_clk);
                hold_off = 30;
            end
        end
        stim_done = 1;
    end

    // Driver: bursts of items with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_item <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (i_valid && !o_ready) begin
            // hold the item until it is taken
        end else if (hold_off > 0) begin
            i_valid <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (gap_left > 0) begin
            i_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_items.size() > 0) begin
            bdk_pkg::t_in_item it;
            it = pending_items.pop_front();
            expected_results.push_back(predict_access(it));
            if (it.operation == bdk_pkg::OP_READ) n_reads++;
            if (it.operation == bdk_pkg::OP_QUEUE_CHAR) n_typed++;
            i_valid <= 1'b1;
            i_item <= it;
            if (burst_left > 0) burst_left <= burst_left - 1;
            else begin
                burst_left <= $urandom_range(0, 12);
                gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Monitor: receiver stalls on a pattern of its own, and checks each result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            n_results <= 0;
        end else begin
            if (o_valid && i_ready) begin
                bdk_pkg::t_out_item want;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_item);
                end else begin
                    want = expected_results.pop_front();
                    if (o_item.read_data !== want.read_data ||
                        o_item.queue_full !== want.queue_full) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: read_data exp %h got %h, queue_full exp %b got %b",
                                     want.read_data, o_item.read_data,
                                     want.queue_full, o_item.queue_full);
                    end
                end
                n_results <= n_results + 1;
            end
            i_ready <= ((cycle_count / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_item = '0;
        cycle_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && pending_items.size() == 0 && !i_valid &&
                 expected_results.size() == 0)) begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("timeout with %0d results outstanding", expected_results.size());
                $display("testbench failed");
                $finish;
            end
        end
        repeat (10) @(posedge i_clk);
        $display("covered %0d results, %0d reads and %0d typed characters,",
                 n_results, n_reads, n_typed);
        $display("with bursty input, receiver stalls and a full typing ring");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("testbench failed");
        end
        $finish;
    end
endmodule
